>>> hw/rtl/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg: shared types and helpers for the palette fade and rotate block
// Palette geometry, transaction structs, codes, sequencer states and the
// offset arithmetic used to map logical palette entries onto RAM rows.
// ----------------------------------------------------------------------------
package pfr_pkg;

	localparam int ENTRIES = 256;
	localparam int CH_BITS = 6;
	localparam int NUM_CH  = 3;
	localparam int ADDR_W  = $clog2(ENTRIES);
	// entries 1 .. ENTRIES-1 take part in fading and rotation
	localparam int SPAN    = ENTRIES - 1;

	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [CH_BITS-1:0] chan_t;

	localparam chan_t CH_MAX = '1;

	typedef enum logic [2:0] {
		KIND_WR_MAIN = 3'd0,
		KIND_WR_TGT  = 3'd1,
		KIND_RD_MAIN = 3'd2,
		KIND_START   = 3'd3,
		KIND_TICK    = 3'd4
	} kind_e;

	localparam logic [1:0] MODE_TARGET = 2'd0;
	localparam logic [1:0] MODE_WHITE  = 2'd1;
	localparam logic [1:0] MODE_BLACK  = 2'd2;
	localparam logic [1:0] MODE_MORPH  = 2'd3;

	localparam logic [1:0] TOG_NONE = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_DRAIN,
		ST_FIN,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] entry_index;
		logic [5:0] red_level;
		logic [5:0] green_level;
		logic [5:0] blue_level;
		logic [1:0] fade_mode;
		logic [1:0] toggle_channel;
	} item_t;

	typedef struct packed {
		logic [5:0] read_red;
		logic [5:0] read_green;
		logic [5:0] read_blue;
		logic       fade_done;
	} result_t;

	// logical entry -> RAM row for a column rotated by off; entry 0 stays put
	function automatic addr_t map_entry(addr_t ent, addr_t off);
		logic [ADDR_W:0] s;
		s = {1'b0, ent - ADDR_W'(1)} + {1'b0, off};
		if (s >= (ADDR_W+1)'(SPAN))
			s = s - (ADDR_W+1)'(SPAN);
		if (ent == '0)
			return '0;
		return s[ADDR_W-1:0] + ADDR_W'(1);
	endfunction

	function automatic addr_t off_inc(addr_t off);
		return (off == ADDR_W'(SPAN - 1)) ? '0 : off + ADDR_W'(1);
	endfunction

	function automatic addr_t off_dec(addr_t off);
		return (off == '0) ? ADDR_W'(SPAN - 1) : off - ADDR_W'(1);
	endfunction

	// (a - b) mod SPAN, both operands below SPAN
	function automatic addr_t off_sub(addr_t a, addr_t b);
		logic [ADDR_W:0] s;
		if (a >= b)
			s = {1'b0, a} - {1'b0, b};
		else
			s = {1'b0, a} + (ADDR_W+1)'(SPAN) - {1'b0, b};
		return s[ADDR_W-1:0];
	endfunction

endpackage

>>> hw/rtl/pfr_ram.sv
// ----------------------------------------------------------------------------
// pfr_ram: generic simple dual-port RAM
// One write port, one read port, read data registered under read enable.
// ----------------------------------------------------------------------------
module pfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/palette_fade_and_rotate.sv
// ----------------------------------------------------------------------------
// palette_fade_and_rotate: palette fade and colour-cycling engine
// Main and target palettes with per-column rotation and a stepwise fade.
// ----------------------------------------------------------------------------
// Usage:
//  - One input channel (item_valid / item_stall / item) and one result channel
//    (result_valid / result_stall / result). Every input transaction yields
//    exactly one result transaction, in order.
//  - Item kinds: write main entry, write target entry, read main entry, start
//    fade (clears the completion flag) and tick (fade, toggle, rotate).
//  - The block handles one transaction at a time; item_stall is high from
//    acceptance until the result has been loaded into the output register.
//  - Writes, start fade and non-fading ticks go straight to the result state;
//    reads pass through a read state first; a fading tick runs the sweep,
//    drain and finish states, one pass over entries 1..ENTRIES-1 of the
//    palette RAMs, one entry per cycle through the main RAM ports.
//  - Rotation costs nothing: each of the six colour columns carries an offset
//    register, and a roll just moves that offset by one.
//  - After reset a clearing pass over all ENTRIES rows zeroes all six
//    column RAMs; item_stall stays high until it finishes.
//  - A stalled result stays in the output register; the next item is still
//    accepted meanwhile, and its result waits until the register is free.
// ----------------------------------------------------------------------------
module palette_fade_and_rotate (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  pfr_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output pfr_pkg::result_t result
);

	localparam pfr_pkg::addr_t LAST_ENTRY = pfr_pkg::ADDR_W'(pfr_pkg::ENTRIES - 1);

	pfr_pkg::state_t state_q, state_d;

	// clearing pass and fade sweep counters
	pfr_pkg::addr_t clr_q;
	pfr_pkg::addr_t p_q;
	logic           valid_s1;
	pfr_pkg::addr_t addr_s1;

	// rotation state per colour column
	pfr_pkg::addr_t [2:0] off_main_q;
	pfr_pkg::addr_t [2:0] off_tgt_q;
	pfr_pkg::addr_t [2:0] diff_q;
	logic [2:0]           dir_q;

	logic flag_q;
	logic all_q;
	logic set_flag_q;
	logic roll_tgt_q;
	logic morph_q;
	logic in_range_q;
	logic [1:0] mode_q;
	logic [1:0] tog_q;
	pfr_pkg::chan_t [2:0] res_chan_q;

	logic             out_valid_q;
	pfr_pkg::result_t out_q;

	// RAM ports
	logic [2:0]           main_we, main_re, tgt_we, tgt_re;
	pfr_pkg::addr_t [2:0] main_waddr, main_raddr, tgt_waddr, tgt_raddr;
	pfr_pkg::chan_t [2:0] main_wdata, main_rdata, tgt_wdata, tgt_rdata;

	logic                 accept;
	logic                 out_free;
	logic                 idx_ok;
	pfr_pkg::addr_t       idx_addr;
	pfr_pkg::chan_t [2:0] level;
	logic                 tick_fade;
	logic                 apply_roll;
	logic                 apply_tgt;
	logic [1:0]           tog_sel;
	logic [2:0]           tog_mask;
	logic [2:0]           dir_new;
	pfr_pkg::chan_t [2:0] goal;
	pfr_pkg::chan_t [2:0] fade_val;
	logic [2:0]           match;

	assign accept   = item_valid && (state_q == pfr_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !result_stall;
	assign idx_ok   = 32'(item.entry_index) < 32'(pfr_pkg::ENTRIES);
	assign idx_addr = pfr_pkg::ADDR_W'(item.entry_index);
	assign level[0] = pfr_pkg::CH_BITS'(item.red_level);
	assign level[1] = pfr_pkg::CH_BITS'(item.green_level);
	assign level[2] = pfr_pkg::CH_BITS'(item.blue_level);

	// a tick runs the fade sweep unless the fade has completed (morph always)
	assign tick_fade = (item.fade_mode == pfr_pkg::MODE_MORPH) || !flag_q;

	assign tog_mask = (tog_sel != pfr_pkg::TOG_NONE) ? (3'b001 << tog_sel) : 3'b000;
	assign dir_new  = dir_q ^ tog_mask;

	assign item_stall   = (state_q != pfr_pkg::ST_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// fade step on the entry read in the previous cycle
	always_comb begin
		for (int c = 0; c < pfr_pkg::NUM_CH; c++) begin
			if (mode_q == pfr_pkg::MODE_WHITE)
				goal[c] = pfr_pkg::CH_MAX;
			else if (mode_q == pfr_pkg::MODE_BLACK)
				goal[c] = '0;
			else
				goal[c] = tgt_rdata[c];
			match[c] = (main_rdata[c] == goal[c]);
			if (main_rdata[c] < goal[c])
				fade_val[c] = main_rdata[c] + pfr_pkg::CH_BITS'(1);
			else if (main_rdata[c] > goal[c])
				fade_val[c] = main_rdata[c] - pfr_pkg::CH_BITS'(1);
			else
				fade_val[c] = main_rdata[c];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= pfr_pkg::ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d    = state_q;
		apply_roll = 1'b0;
		apply_tgt  = 1'b0;
		tog_sel    = item.toggle_channel;
		case (state_q)
			pfr_pkg::ST_CLEAR: begin
				if (clr_q == LAST_ENTRY)
					state_d = pfr_pkg::ST_IDLE;
			end
			pfr_pkg::ST_IDLE: begin
				if (accept) begin
					if (item.kind == pfr_pkg::KIND_RD_MAIN) begin
						state_d = pfr_pkg::ST_READ;
					end else if (item.kind == pfr_pkg::KIND_TICK && tick_fade) begin
						state_d = pfr_pkg::ST_SWEEP;
					end else begin
						state_d = pfr_pkg::ST_RESULT;
						// target mode after completion: main palette rolls only
						if (item.kind == pfr_pkg::KIND_TICK &&
						    item.fade_mode == pfr_pkg::MODE_TARGET)
							apply_roll = 1'b1;
					end
				end
			end
			pfr_pkg::ST_READ: begin
				state_d = pfr_pkg::ST_RESULT;
			end
			pfr_pkg::ST_SWEEP: begin
				if (p_q == LAST_ENTRY)
					state_d = pfr_pkg::ST_DRAIN;
			end
			pfr_pkg::ST_DRAIN: begin
				state_d = pfr_pkg::ST_FIN;
			end
			pfr_pkg::ST_FIN: begin
				state_d    = pfr_pkg::ST_RESULT;
				apply_roll = 1'b1;
				apply_tgt  = roll_tgt_q;
				tog_sel    = tog_q;
			end
			pfr_pkg::ST_RESULT: begin
				if (out_free)
					state_d = pfr_pkg::ST_IDLE;
			end
			default: begin
				state_d = pfr_pkg::ST_CLEAR;
			end
		endcase
	end

	// RAM port steering
	always_comb begin
		for (int c = 0; c < pfr_pkg::NUM_CH; c++) begin
			main_we[c]    = 1'b0;
			main_waddr[c] = clr_q;
			main_wdata[c] = '0;
			main_re[c]    = 1'b0;
			main_raddr[c] = p_q;
			tgt_we[c]     = 1'b0;
			tgt_waddr[c]  = clr_q;
			tgt_wdata[c]  = '0;
			tgt_re[c]     = 1'b0;
			tgt_raddr[c]  = pfr_pkg::map_entry(p_q, diff_q[c]);
			case (state_q)
				pfr_pkg::ST_CLEAR: begin
					main_we[c] = 1'b1;
					tgt_we[c]  = 1'b1;
				end
				pfr_pkg::ST_IDLE: begin
					main_waddr[c] = pfr_pkg::map_entry(idx_addr, off_main_q[c]);
					main_raddr[c] = pfr_pkg::map_entry(idx_addr, off_main_q[c]);
					main_wdata[c] = level[c];
					tgt_waddr[c]  = pfr_pkg::map_entry(idx_addr, off_tgt_q[c]);
					tgt_wdata[c]  = level[c];
					if (accept && idx_ok) begin
						main_we[c] = (item.kind == pfr_pkg::KIND_WR_MAIN);
						tgt_we[c]  = (item.kind == pfr_pkg::KIND_WR_TGT);
						main_re[c] = (item.kind == pfr_pkg::KIND_RD_MAIN);
					end
				end
				pfr_pkg::ST_SWEEP: begin
					main_re[c] = 1'b1;
					tgt_re[c]  = 1'b1;
				end
				default: begin
				end
			endcase
			// write-back of the faded entry in the cycle after the read
			if (valid_s1) begin
				main_we[c]    = 1'b1;
				main_waddr[c] = addr_s1;
				main_wdata[c] = fade_val[c];
			end
		end
	end

	for (genvar c = 0; c < pfr_pkg::NUM_CH; c++) begin : g_col
		pfr_ram #(
			.WIDTH(pfr_pkg::CH_BITS),
			.DEPTH(pfr_pkg::ENTRIES)
		) u_main (
			.clk  (clk),
			.we   (main_we[c]),
			.waddr(main_waddr[c]),
			.wdata(main_wdata[c]),
			.re   (main_re[c]),
			.raddr(main_raddr[c]),
			.rdata(main_rdata[c])
		);
		pfr_ram #(
			.WIDTH(pfr_pkg::CH_BITS),
			.DEPTH(pfr_pkg::ENTRIES)
		) u_tgt (
			.clk  (clk),
			.we   (tgt_we[c]),
			.waddr(tgt_waddr[c]),
			.wdata(tgt_wdata[c]),
			.re   (tgt_re[c]),
			.raddr(tgt_raddr[c]),
			.rdata(tgt_rdata[c])
		);
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			p_q         <= pfr_pkg::ADDR_W'(1);
			valid_s1    <= 1'b0;
			off_main_q  <= '0;
			off_tgt_q   <= '0;
			diff_q      <= '0;
			dir_q       <= '0;
			flag_q      <= 1'b0;
			all_q       <= 1'b0;
			set_flag_q  <= 1'b0;
			roll_tgt_q  <= 1'b0;
			morph_q     <= 1'b0;
			in_range_q  <= 1'b0;
			mode_q      <= '0;
			tog_q       <= '0;
			res_chan_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == pfr_pkg::ST_CLEAR)
				clr_q <= clr_q + pfr_pkg::ADDR_W'(1);

			valid_s1 <= (state_q == pfr_pkg::ST_SWEEP);

			if (accept) begin
				mode_q     <= item.fade_mode;
				tog_q      <= item.toggle_channel;
				morph_q    <= (item.kind == pfr_pkg::KIND_TICK) &&
				              (item.fade_mode == pfr_pkg::MODE_MORPH);
				set_flag_q <= (item.fade_mode != pfr_pkg::MODE_MORPH);
				roll_tgt_q <= (item.fade_mode == pfr_pkg::MODE_TARGET) ||
				              (item.fade_mode == pfr_pkg::MODE_MORPH);
				in_range_q <= idx_ok;
				res_chan_q <= '0;
				p_q        <= pfr_pkg::ADDR_W'(1);
				all_q      <= 1'b1;
				for (int c = 0; c < pfr_pkg::NUM_CH; c++)
					diff_q[c] <= pfr_pkg::off_sub(off_tgt_q[c], off_main_q[c]);
				if (item.kind == pfr_pkg::KIND_START)
					flag_q <= 1'b0;
			end

			if (state_q == pfr_pkg::ST_SWEEP)
				p_q <= p_q + pfr_pkg::ADDR_W'(1);

			if (valid_s1)
				all_q <= all_q & (&match);

			if (state_q == pfr_pkg::ST_READ && in_range_q)
				res_chan_q <= main_rdata;

			if (state_q == pfr_pkg::ST_FIN && set_flag_q && all_q)
				flag_q <= 1'b1;

			// toggle first, then roll with the new directions
			if (apply_roll) begin
				dir_q <= dir_new;
				for (int c = 0; c < pfr_pkg::NUM_CH; c++) begin
					off_main_q[c] <= dir_new[c] ? pfr_pkg::off_dec(off_main_q[c])
					                            : pfr_pkg::off_inc(off_main_q[c]);
					if (apply_tgt)
						off_tgt_q[c] <= dir_new[c] ? pfr_pkg::off_dec(off_tgt_q[c])
						                           : pfr_pkg::off_inc(off_tgt_q[c]);
				end
			end

			if (state_q == pfr_pkg::ST_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (state_q == pfr_pkg::ST_RESULT && out_free) begin
			out_q.read_red   <= 6'(res_chan_q[0]);
			out_q.read_green <= 6'(res_chan_q[1]);
			out_q.read_blue  <= 6'(res_chan_q[2]);
			out_q.fade_done  <= morph_q ? all_q : flag_q;
		end
		addr_s1 <= p_q;
	end

endmodule

>>> hw/rtl/pfr_checker.sv
// ----------------------------------------------------------------------------
// pfr_checker: port-level checks for the palette fade and rotate block
// Tracks outstanding transactions and checks ordering of the handshakes.
// ----------------------------------------------------------------------------
module pfr_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input pfr_pkg::result_t result
);

	logic       acc_in;
	logic       acc_out;
	logic [1:0] pend_q;

	assign acc_in  = item_valid && !item_stall;
	assign acc_out = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + 2'(acc_in) - 2'(acc_out);
	end

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// one transaction in work at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item accepted back to back");

	// no result without an accepted item
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pend_q != 2'd0)
		else $error("result without transaction");

	// at most one in work plus one waiting in the output register
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many outstanding transactions");

endmodule

bind palette_fade_and_rotate pfr_checker u_pfr_checker (.*);
